### hdl/ffha_pkg.sv
// Shared constants and codes for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

	localparam int DEF_MAX_BLOCKS = 64;
	localparam int DEF_ADDR_BITS  = 24;
	localparam int PORT_BITS      = 24;
	localparam int HEAP_BITS      = 25;
	localparam int HDR_BYTES      = 32;
	localparam int SPLIT_MIN      = 32;
	localparam int HEAP_RESET     = 1048576;
	localparam int HEAP_MIN       = 64;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO     = 2'd1,
		ST_OOM      = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

endpackage

### hdl/first_fit_heap_allocator_core.sv
// First-fit heap allocator core: block list memories and walk sequencer.
// Depends on ffha_pkg.
//
// Usage: an item (operation, request_size, address) enters on in_valid/in_ready and
// one result (result_address, status) leaves on out_valid/out_ready. The block
// takes one item at a time; in_ready is high only while the sequencer is idle.
// Allocate walks the address-ordered block list one entry per cycle through the
// registered read port of the block memories; when the block is split, it then
// scans for a spare slot and updates the list. Free scans slots in order one per
// cycle to find the data offset, then runs the merge checks, merges the next
// block when it is free and then merges into the previous block when that one
// is free. Zero size and null free go straight to the final state.
// A result waits in the output register while the receiver stalls; the
// sequencer holds in its final state until that register is free.
// Reset and each write of heap_bytes (cfg_we/cfg_wdata) set the region to one
// free block; the next cycle writes slot 0 and the block is then ready.
module first_fit_heap_allocator_core
	import ffha_pkg::*;
#(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
	parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [HEAP_BITS-1:0] cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [PORT_BITS-1:0] request_size,
	input  logic [PORT_BITS-1:0] address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PORT_BITS-1:0] result_address,
	output logic [1:0]           status
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LW = $clog2(MAX_BLOCKS + 1);
	localparam int AB = ADDR_BITS;
	localparam int CW = ((AB > PORT_BITS) ? AB : PORT_BITS) + 2;
	localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);
	localparam logic [IW-1:0] LAST_IX = IW'(MAX_BLOCKS - 1);
	localparam logic [HEAP_BITS-1:0] TOP_BYTES =
		(AB < 24) ? HEAP_BITS'(1 << AB) : HEAP_BITS'(1 << 24);
	localparam logic [HEAP_BITS-1:0] FLOOR_BYTES = HEAP_BITS'(HEAP_MIN);
	localparam logic [HEAP_BITS-1:0] RST_BYTES =
		(HEAP_BITS'(HEAP_RESET) > TOP_BYTES) ? TOP_BYTES : HEAP_BITS'(HEAP_RESET);
	localparam logic [CW-1:0] HDR_C = CW'(HDR_BYTES);
	localparam logic [CW-1:0] SPLIT_C = CW'(HDR_BYTES + SPLIT_MIN);

	typedef enum logic [12:0] {
		S_INIT  = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_CHK   = 13'b0000000000100,
		S_SPARE = 13'b0000000001000,
		S_SPL1  = 13'b0000000010000,
		S_SPL2  = 13'b0000000100000,
		S_FSC   = 13'b0000001000000,
		S_M0    = 13'b0000010000000,
		S_M1    = 13'b0000100000000,
		S_MDONE = 13'b0001000000000,
		S_FLP   = 13'b0010000000000,
		S_FIN   = 13'b0100000000000,
		S_SPARE2 = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [AB-1:0] off_mem  [MAX_BLOCKS];
	logic [AB-1:0] size_mem [MAX_BLOCKS];
	logic [LW-1:0] next_mem [MAX_BLOCKS];
	logic [LW-1:0] prev_mem [MAX_BLOCKS];
	logic [AB-1:0] off_rd_q, size_rd_q;
	logic [LW-1:0] next_rd_q, prev_rd_q;

	logic [MAX_BLOCKS-1:0] valid_q, inuse_q;
	logic [HEAP_BITS-1:0]  heap_q;
	logic [CW-1:0]         rsz_q;
	logic [PORT_BITS-1:0]  addr_q;
	logic [LW-1:0]         cur_q, cur_next_q, s_next_q, h_prev_q;
	logic [IW-1:0]         i_q, s_q;
	logic [AB-1:0]         cur_off_q, cur_size_q, s_size_q;
	logic                  second_q;
	logic [PORT_BITS-1:0]  res_q;
	status_t               st_q;
	logic                  out_valid_q;
	logic [PORT_BITS-1:0]  out_addr_q;
	logic [1:0]            out_st_q;

	logic [IW-1:0]         raddr;
	logic                  off_we, size_we, next_we, prev_we;
	logic [IW-1:0]         off_wa, size_wa, next_wa, prev_wa;
	logic [AB-1:0]         off_wd, size_wd;
	logic [LW-1:0]         next_wd, prev_wd;

	logic [HEAP_BITS-1:0]  cfg_lim;
	logic [IW-1:0]         cur_ix, n_ix, p_ix, cn_ix;
	logic                  fit, split_ok, fs_hit, m_ok, p_ok, out_free;
	logic [CW-1:0]         size_c, off_hdr;

	assign cfg_lim = (cfg_wdata < FLOOR_BYTES) ? FLOOR_BYTES :
		((cfg_wdata > TOP_BYTES) ? TOP_BYTES : cfg_wdata);
	assign cur_ix = cur_q[IW-1:0];
	assign n_ix = s_next_q[IW-1:0];
	assign p_ix = h_prev_q[IW-1:0];
	assign cn_ix = cur_next_q[IW-1:0];
	assign size_c = CW'(size_rd_q);
	assign off_hdr = CW'(off_rd_q) + HDR_C;
	assign fit = valid_q[cur_ix] && !inuse_q[cur_ix] && (size_c >= rsz_q);
	assign split_ok = size_c >= rsz_q + SPLIT_C;
	assign fs_hit = valid_q[i_q] && (off_hdr == CW'(addr_q));
	assign m_ok = (s_next_q != NULL_LINK) && valid_q[n_ix] && !inuse_q[n_ix];
	assign p_ok = (h_prev_q != NULL_LINK) && valid_q[p_ix] && !inuse_q[p_ix];
	assign out_free = !out_valid_q || out_ready;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign result_address = out_addr_q;
	assign status = out_st_q;

	always_comb begin
		raddr = '0;
		off_we = 1'b0;
		size_we = 1'b0;
		next_we = 1'b0;
		prev_we = 1'b0;
		off_wa = '0;
		size_wa = '0;
		next_wa = '0;
		prev_wa = '0;
		off_wd = '0;
		size_wd = '0;
		next_wd = NULL_LINK;
		prev_wd = NULL_LINK;
		unique case (state_q)
			S_INIT: begin
				off_we = 1'b1;
				size_we = 1'b1;
				next_we = 1'b1;
				prev_we = 1'b1;
				size_wd = AB'(heap_q - HEAP_BITS'(HDR_BYTES));
			end
			S_CHK: raddr = next_rd_q[IW-1:0];
			S_FSC: raddr = (i_q == LAST_IX) ? '0 : i_q + 1'b1;
			S_M0: raddr = n_ix;
			S_M1: begin
				size_we = 1'b1;
				size_wa = s_q;
				size_wd = AB'(CW'(s_size_q) + HDR_C + size_c);
				next_we = 1'b1;
				next_wa = s_q;
				next_wd = next_rd_q;
				prev_we = (next_rd_q != NULL_LINK);
				prev_wa = next_rd_q[IW-1:0];
				prev_wd = LW'(s_q);
			end
			S_MDONE: raddr = p_ix;
			S_SPL1: begin
				off_we = 1'b1;
				off_wa = i_q;
				off_wd = AB'(CW'(cur_off_q) + HDR_C + rsz_q);
				size_we = 1'b1;
				size_wa = i_q;
				size_wd = AB'(CW'(cur_size_q) - rsz_q - HDR_C);
				next_we = 1'b1;
				next_wa = i_q;
				next_wd = cur_next_q;
				prev_we = 1'b1;
				prev_wa = i_q;
				prev_wd = cur_q;
			end
			S_SPL2: begin
				prev_we = (cur_next_q != NULL_LINK);
				prev_wa = cn_ix;
				prev_wd = LW'(i_q);
				next_we = 1'b1;
				next_wa = cur_ix;
				next_wd = LW'(i_q);
				size_we = 1'b1;
				size_wa = cur_ix;
				size_wd = AB'(rsz_q);
			end
			default: raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (off_we) off_mem[off_wa] <= off_wd;
		if (size_we) size_mem[size_wa] <= size_wd;
		if (next_we) next_mem[next_wa] <= next_wd;
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		off_rd_q <= off_mem[raddr];
		size_rd_q <= size_mem[raddr];
		next_rd_q <= next_mem[raddr];
		prev_rd_q <= prev_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			heap_q <= RST_BYTES;
			valid_q <= MAX_BLOCKS'(1);
			inuse_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!cfg_we && state_q == S_FIN && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				heap_q <= cfg_lim;
				valid_q <= MAX_BLOCKS'(1);
				inuse_q <= '0;
				state_q <= S_INIT;
			end else begin
				unique case (state_q)
					S_INIT: state_q <= S_IDLE;
					S_IDLE: begin
						if (in_valid) begin
							rsz_q <= (CW'(request_size) + CW'(7)) & ~CW'(7);
							addr_q <= address;
							cur_q <= '0;
							i_q <= '0;
							second_q <= 1'b0;
							res_q <= '0;
							st_q <= ST_OK;
							if (!operation) begin
								if (request_size == '0) begin
									st_q <= ST_ZERO;
									state_q <= S_FIN;
								end else begin
									state_q <= S_CHK;
								end
							end else if (address == '0) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_FSC;
							end
						end
					end
					S_CHK: begin
						if (fit) begin
							inuse_q[cur_ix] <= 1'b1;
							cur_off_q <= off_rd_q;
							cur_size_q <= size_rd_q;
							cur_next_q <= next_rd_q;
							res_q <= off_hdr[PORT_BITS-1:0];
							i_q <= '0;
							state_q <= split_ok ? S_SPARE : S_FIN;
						end else if (next_rd_q == NULL_LINK) begin
							st_q <= ST_OOM;
							state_q <= S_FIN;
						end else begin
							cur_q <= next_rd_q;
						end
					end
					S_SPARE: begin
						if (!valid_q[i_q]) state_q <= S_SPL1;
						else if (i_q == LAST_IX) state_q <= S_FIN;
						else i_q <= i_q + 1'b1;
					end
					S_SPL1: begin
						valid_q[i_q] <= 1'b1;
						inuse_q[i_q] <= 1'b0;
						state_q <= S_SPL2;
					end
					S_SPL2: state_q <= S_FIN;
					S_FSC: begin
						if (fs_hit) begin
							inuse_q[i_q] <= 1'b0;
							s_q <= i_q;
							s_size_q <= size_rd_q;
							s_next_q <= next_rd_q;
							h_prev_q <= prev_rd_q;
							state_q <= S_M0;
						end else if (i_q == LAST_IX) begin
							st_q <= ST_NOTFOUND;
							state_q <= S_FIN;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
					S_M0: state_q <= m_ok ? S_M1 : S_MDONE;
					S_M1: begin
						valid_q[n_ix] <= 1'b0;
						inuse_q[n_ix] <= 1'b0;
						state_q <= S_MDONE;
					end
					S_MDONE: begin
						if (!second_q && p_ok) begin
							second_q <= 1'b1;
							state_q <= S_FLP;
						end else begin
							state_q <= S_FIN;
						end
					end
					S_FLP: begin
						s_q <= p_ix;
						s_size_q <= size_rd_q;
						s_next_q <= next_rd_q;
						state_q <= S_M0;
					end
					S_FIN: begin
						if (out_free) begin
							out_addr_q <= res_q;
							out_st_q <= st_q;
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule

### tb/first_fit_heap_allocator_core_tb.sv
// Testbench for first_fit_heap_allocator_core: directed and random allocate/free items,
// checked against a behavioral block-list model of the heap.
// Depends on ffha_pkg and the core RTL.
module first_fit_heap_allocator_core_tb
	import ffha_pkg::*;
;

	localparam int SLOTS      = DEF_MAX_BLOCKS;
	localparam int NO_LINK    = SLOTS;
	localparam int DRAIN      = 300;
	localparam int STALL_MAX  = 4000;
	localparam bit OP_ALLOC   = 1'b0;
	localparam bit OP_FREE    = 1'b1;

	typedef struct packed {
		logic [PORT_BITS-1:0] addr;
		status_t              st;
	} alloc_reply_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [HEAP_BITS-1:0] cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic                 operation;
	logic [PORT_BITS-1:0] request_size;
	logic [PORT_BITS-1:0] address;
	logic                 out_valid;
	logic                 out_ready;
	logic [PORT_BITS-1:0] result_address;
	logic [1:0]           status;

	first_fit_heap_allocator_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.request_size(request_size), .address(address), .out_valid(out_valid),
		.out_ready(out_ready), .result_address(result_address), .status(status)
	);

	// heap model state
	bit [HEAP_BITS-1:0] heap_len;
	bit [PORT_BITS-1:0] blk_off [SLOTS];
	bit [HEAP_BITS-1:0] blk_len [SLOTS];
	bit                 blk_used [SLOTS];
	bit                 blk_live [SLOTS];
	int                 blk_next [SLOTS];
	int                 blk_prev [SLOTS];

	alloc_reply_t       reply_q[$];
	logic [PORT_BITS-1:0] held_addrs[$];
	logic [PORT_BITS-1:0] last_freed;
	int                 errors;
	int                 quiet_cycles;
	int                 tx_idle;
	int                 rx_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic model_reset(input logic [HEAP_BITS-1:0] v);
		longint unsigned b;
		b = v;
		if (b < HEAP_MIN) b = HEAP_MIN;
		if (b > (64'd1 << DEF_ADDR_BITS)) b = 64'd1 << DEF_ADDR_BITS;
		heap_len = HEAP_BITS'(b);
		for (int i = 0; i < SLOTS; i++) begin
			blk_off[i] = '0;
			blk_len[i] = '0;
			blk_used[i] = 1'b0;
			blk_live[i] = 1'b0;
			blk_next[i] = NO_LINK;
			blk_prev[i] = NO_LINK;
		end
		blk_live[0] = 1'b1;
		blk_len[0] = HEAP_BITS'(heap_len - HDR_BYTES);
		held_addrs.delete();
	endtask

	task automatic absorb_next(input int s);
		int n;
		int nn;
		n = blk_next[s];
		if (n >= SLOTS || !blk_live[n] || blk_used[n]) return;
		blk_len[s] = HEAP_BITS'(blk_len[s] + HDR_BYTES + blk_len[n]);
		nn = blk_next[n];
		blk_next[s] = nn;
		if (nn < SLOTS) blk_prev[nn] = s;
		blk_live[n] = 1'b0;
		blk_used[n] = 1'b0;
		blk_off[n] = '0;
		blk_len[n] = '0;
		blk_next[n] = NO_LINK;
		blk_prev[n] = NO_LINK;
	endtask

	task automatic heap_predict(input bit op, input logic [PORT_BITS-1:0] req,
			input logic [PORT_BITS-1:0] addr, output alloc_reply_t r);
		longint unsigned want;
		int cur;
		int steps;
		int ns;
		int hit;
		int p;
		r.addr = '0;
		r.st = ST_OK;
		if (op == OP_ALLOC) begin
			if (req == 0) begin
				r.st = ST_ZERO;
			end else begin
				want = (longint'(req) + 7) & ~64'd7;
				cur = 0;
				steps = 0;
				r.st = ST_OOM;
				while (cur < SLOTS && steps < SLOTS) begin
					if (blk_live[cur] && !blk_used[cur] && blk_len[cur] >= want) begin
						if (blk_len[cur] >= want + HDR_BYTES + SPLIT_MIN) begin
							ns = NO_LINK;
							for (int i = 0; i < SLOTS; i++)
								if (!blk_live[i] && ns == NO_LINK) ns = i;
							if (ns < SLOTS) begin
								blk_live[ns] = 1'b1;
								blk_used[ns] = 1'b0;
								blk_off[ns] = PORT_BITS'(blk_off[cur] + HDR_BYTES + want);
								blk_len[ns] = HEAP_BITS'(blk_len[cur] - want - HDR_BYTES);
								blk_next[ns] = blk_next[cur];
								blk_prev[ns] = cur;
								if (blk_next[cur] < SLOTS) blk_prev[blk_next[cur]] = ns;
								blk_next[cur] = ns;
								blk_len[cur] = HEAP_BITS'(want);
							end
						end
						blk_used[cur] = 1'b1;
						r.addr = PORT_BITS'(blk_off[cur] + HDR_BYTES);
						r.st = ST_OK;
						break;
					end
					cur = blk_next[cur];
					steps++;
				end
			end
		end else if (addr != 0) begin
			hit = NO_LINK;
			for (int i = 0; i < SLOTS; i++)
				if (hit == NO_LINK && blk_live[i] && longint'(blk_off[i]) + HDR_BYTES == addr)
					hit = i;
			if (hit == NO_LINK) begin
				r.st = ST_NOTFOUND;
			end else begin
				blk_used[hit] = 1'b0;
				absorb_next(hit);
				p = blk_prev[hit];
				if (p < SLOTS && blk_live[p] && !blk_used[p]) absorb_next(p);
			end
		end
	endtask

	task automatic send_item(input bit op, input logic [PORT_BITS-1:0] req,
			input logic [PORT_BITS-1:0] addr);
		int gap;
		alloc_reply_t r;
		gap = 0;
		while ($urandom_range(99) < tx_idle && gap < 20) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		request_size <= req;
		address <= addr;
		do @(posedge clk); while (!in_ready);
		heap_predict(op, req, addr, r);
		reply_q.push_back(r);
		if (op == OP_ALLOC && r.st == ST_OK) held_addrs.push_back(r.addr);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_heap(input logic [HEAP_BITS-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_reset(v);
	endtask

	task automatic free_held(input int idx);
		last_freed = held_addrs[idx];
		held_addrs.delete(idx);
		send_item(OP_FREE, PORT_BITS'($urandom), last_freed);
	endtask

	task automatic test_directed();
		logic [PORT_BITS-1:0] a;
		logic [PORT_BITS-1:0] b;
		logic [PORT_BITS-1:0] c;
		send_item(OP_ALLOC, 24'd0, 24'hFFFFFF);
		send_item(OP_ALLOC, 24'd1, 24'd0);
		send_item(OP_ALLOC, 24'hFFFFFF, 24'd0);
		send_item(OP_FREE, 24'hFFFFFF, 24'd0);
		send_item(OP_FREE, 24'd0, 24'd12345);
		send_item(OP_FREE, 24'd0, 24'hFFFFFF);
		send_item(OP_FREE, 24'd0, 24'd32);
		send_item(OP_FREE, 24'd0, 24'd32);
		send_item(OP_ALLOC, 24'd100, 24'd0);
		send_item(OP_ALLOC, 24'd200, 24'd0);
		send_item(OP_ALLOC, 24'd300, 24'd0);
		a = held_addrs[0];
		b = held_addrs[1];
		c = held_addrs[2];
		send_item(OP_FREE, 24'd0, b);
		send_item(OP_FREE, 24'd0, a);
		send_item(OP_FREE, 24'd0, c);
		send_item(OP_ALLOC, 24'd1048000, 24'd0);
		write_heap('0);
		send_item(OP_ALLOC, 24'd40, 24'd0);
		send_item(OP_ALLOC, 24'd32, 24'd0);
		send_item(OP_ALLOC, 24'd1, 24'd0);
		write_heap(25'h1FFFFFF);
		send_item(OP_ALLOC, 24'hFFFFE0, 24'd0);
		send_item(OP_ALLOC, 24'hFFFFD9, 24'd0);
		send_item(OP_FREE, 24'd0, 24'd32);
		write_heap(25'd64);
		send_item(OP_ALLOC, 24'd25, 24'd0);
	endtask

	task automatic test_random(input int n, input logic [HEAP_BITS-1:0] heap_v);
		int k;
		int sel;
		write_heap(heap_v);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 4) begin
				send_item(OP_ALLOC, 24'd0, PORT_BITS'($urandom));
			end else if (k < 9) begin
				send_item(OP_FREE, PORT_BITS'($urandom), PORT_BITS'($urandom));
			end else if (k < 12) begin
				send_item(OP_FREE, PORT_BITS'($urandom), last_freed);
			end else if (k < 16) begin
				send_item(OP_ALLOC, PORT_BITS'($urandom), PORT_BITS'($urandom));
			end else if (k < 58 || held_addrs.size() == 0) begin
				sel = $urandom_range(1, 1 << $urandom_range(3, 14));
				send_item(OP_ALLOC, PORT_BITS'(sel), PORT_BITS'($urandom));
			end else begin
				free_held($urandom_range(held_addrs.size() - 1));
			end
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle);
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX) begin
			$display("first_fit_heap_allocator_core_tb: FAIL");
			$finish;
		end
		if (out_valid && out_ready) begin
			if (reply_q.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				if (result_address !== reply_q[0].addr)
					report_mismatch($sformatf("result_address %h, want %h",
						result_address, reply_q[0].addr));
				if (status !== reply_q[0].st)
					report_mismatch($sformatf("status %0d, want %0d",
						status, reply_q[0].st));
				void'(reply_q.pop_front());
			end
		end
	end

	initial begin
		errors = 0;
		quiet_cycles = 0;
		tx_idle = 37;
		rx_idle = 50;
		last_freed = 24'd32;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		operation = 1'b0;
		request_size = '0;
		address = '0;
		out_ready = 1'b0;
		model_reset(HEAP_BITS'(HEAP_RESET));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(540, HEAP_BITS'(HEAP_RESET));
		tx_idle = 50;
		rx_idle = 37;
		test_random(540, 25'h1000000);
		tx_idle = 0;
		rx_idle = 0;
		test_random(540, HEAP_BITS'($urandom_range(64, 8192)));
		wait_idle();
		if (errors == 0 && reply_q.size() == 0) begin
			$display("first_fit_heap_allocator_core_tb: PASS");
		end else begin
			$display("first_fit_heap_allocator_core_tb: FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/ffha_pkg.sv
hdl/first_fit_heap_allocator_core.sv
tb/first_fit_heap_allocator_core_tb.sv
